>>> rtl/b64sd_pkg.sv
package b64sd_pkg;

   // Default number of entries in the queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One unit of work for the back end: up to three bytes of a quad, or an error.
   typedef struct packed {
      logic        err;
      logic        fin;
      logic [1:0]  count;
      logic [23:0] block;
   } job_type;

endpackage

>>> rtl/b64sd_req_if.sv
interface b64sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink (input valid, input char_code, input final_char, output ready);
endinterface

>>> rtl/b64sd_rsp_if.sv
interface b64sd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       status;
   logic       end_of_string;

   modport source (output valid, output data_byte, output status, output end_of_string,
                   input ready);
   modport sink (input valid, input data_byte, input status, input end_of_string,
                 output ready);
endinterface

>>> rtl/b64sd_front.sv
module b64sd_front (
   input  logic                clock,
   input  logic                reset,
   b64sd_req_if.sink           req_chan,
   input  logic                queue_full,
   output logic                push_valid,
   output b64sd_pkg::job_type  push_job
);

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;
   localparam logic [7:0] CHAR_DIGIT = 8'h30;
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;

   logic [1:0]  quad_ff, quad_in;
   logic [17:0] held_ff, held_in;
   logic        third_pad_ff, third_pad_in;
   logic        discard_ff, discard_in;

   logic        accept;
   logic [7:0]  ch;
   logic        fin;
   logic        pad;
   logic        ok;
   logic [5:0]  sextet;
   logic        err;
   logic        emit;
   logic [1:0]  count;
   logic [23:0] block;

   always_comb begin
      ok     = 1'b1;
      sextet = '0;
      case (ch) inside
         [8'h41:8'h5A]: sextet = 6'(ch - CHAR_UPPER);
         [8'h61:8'h7A]: sextet = 6'(ch - CHAR_LOWER + LOWER_BASE);
         [8'h30:8'h39]: sextet = 6'(ch - CHAR_DIGIT + DIGIT_BASE);
         CHAR_PLUS:     sextet = 6'd62;
         CHAR_SLASH:    sextet = 6'd63;
         default:       ok = 1'b0;
      endcase
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !queue_full;
   assign ch             = req_chan.char_code;
   assign fin            = req_chan.final_char;
   assign pad            = (ch == CHAR_PAD);
   assign block          = {held_ff, (pad ? 6'd0 : sextet)};

   always_comb begin
      quad_in      = quad_ff;
      held_in      = held_ff;
      third_pad_in = third_pad_ff;
      discard_in   = discard_ff;
      err          = 1'b0;
      emit         = 1'b0;
      count        = 2'd3 - {1'b0, third_pad_ff} - {1'b0, pad};
      if (accept) begin
         if (discard_ff) begin
            if (fin) begin
               discard_in   = 1'b0;
               quad_in      = '0;
               held_in      = '0;
               third_pad_in = 1'b0;
            end
         end else if (quad_ff != 2'd3) begin
            if (fin) begin
               err = 1'b1;
            end else if (quad_ff == 2'd2 && pad) begin
               third_pad_in = 1'b1;
               held_in      = {held_ff[11:0], 6'd0};
               quad_in      = quad_ff + 2'd1;
            end else if (!ok) begin
               err = 1'b1;
            end else begin
               held_in = {held_ff[11:0], sextet};
               quad_in = quad_ff + 2'd1;
            end
         end else begin
            // Fourth slot: padding is legal only in the final quad, in canonical form.
            if ((third_pad_ff || pad) && !fin) begin
               err = 1'b1;
            end else if (third_pad_ff && !pad) begin
               err = 1'b1;
            end else if (!pad && !ok) begin
               err = 1'b1;
            end else if (third_pad_ff && held_ff[9:6] != 4'd0) begin
               err = 1'b1;
            end else if (pad && !third_pad_ff && held_ff[1:0] != 2'd0) begin
               err = 1'b1;
            end else begin
               emit = 1'b1;
            end
            quad_in      = '0;
            held_in      = '0;
            third_pad_in = 1'b0;
         end
         if (err) begin
            quad_in      = '0;
            held_in      = '0;
            third_pad_in = 1'b0;
            discard_in   = !fin;
         end
      end
   end

   always_comb begin
      push_valid = emit || err;
      push_job   = '0;
      if (err) begin
         push_job.err   = 1'b1;
         push_job.fin   = 1'b1;
         push_job.count = 2'd1;
      end else begin
         push_job.fin   = fin;
         push_job.count = count;
         push_job.block = block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff      <= '0;
         held_ff      <= '0;
         third_pad_ff <= 1'b0;
         discard_ff   <= 1'b0;
      end else begin
         quad_ff      <= quad_in;
         held_ff      <= held_in;
         third_pad_ff <= third_pad_in;
         discard_ff   <= discard_in;
      end
   end

endmodule

>>> rtl/b64sd_queue.sv
module b64sd_queue #(
   parameter int DEPTH = b64sd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  b64sd_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output b64sd_pkg::job_type  pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   b64sd_pkg::job_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/b64sd_back.sv
module b64sd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  b64sd_pkg::job_type  job,
   output logic                job_pop,
   b64sd_rsp_if.source         rsp_chan
);

   b64sd_pkg::job_type cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [1:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         data_ff, data_in;
   logic               status_ff, status_in;
   logic               end_ff, end_in;

   logic               out_free;
   logic               advance;
   logic               last;
   logic [7:0]         byte_sel;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = out_free && cur_valid_ff;
   assign last     = cur_ff.err || (idx_ff == cur_ff.count - 2'd1);
   assign job_pop  = (!cur_valid_ff || (advance && last)) && job_valid;

   always_comb begin
      case (idx_ff)
         2'd0:    byte_sel = cur_ff.block[23:16];
         2'd1:    byte_sel = cur_ff.block[15:8];
         default: byte_sel = cur_ff.block[7:0];
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      end_in       = end_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         data_in      = byte_sel;
         status_in    = cur_ff.err;
         end_in       = cur_ff.fin && last;
         idx_in       = idx_ff + 2'd1;
         if (last) begin
            cur_valid_in = 1'b0;
         end
      end
      // The next job is taken when no job is held, or in the cycle its predecessor hands over its final byte.
      if (job_pop) begin
         cur_in       = job;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_byte     = data_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.end_of_string = end_ff;

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      data_ff <= data_in;
      status_ff <= status_in;
      end_ff  <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/base64_strict_decoder_core.sv
// Channel    Direction  Payload
// req_chan   in         char_code[7:0], final_char
// rsp_chan   out        data_byte[7:0], status, end_of_string
//
// One character is accepted per cycle while the job queue has room; decoding of a
// character is done in the cycle it is accepted. Each quad or error becomes one job,
// and the back end sends one result byte per cycle, while rsp_chan is ready, from a
// registered output stage that follows the queue and a current-job register.
// Reset is synchronous and clears the quad state, the queue and the output stage.
// A stalled result side backs up the queue (QUEUE_DEPTH jobs), then req_chan.ready drops.
module base64_strict_decoder_core #(
   parameter int QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   b64sd_req_if.sink    req_chan,
   b64sd_rsp_if.source  rsp_chan
);

   logic               push_valid;
   b64sd_pkg::job_type push_job;
   logic               queue_full;
   logic               pop;
   logic               pop_valid;
   b64sd_pkg::job_type pop_job;

   b64sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   b64sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
